@@ rtl/bau_pkg.sv @@
// Shared types and constants for the byte arithmetic unit.
// No dependencies; imported by bau_cell and byte_alu_add_sub_mul_div_core.
`default_nettype none

package bau_pkg;

  localparam int WORD_BITS = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [WORD_BITS-1:0] a_value;
    logic [WORD_BITS-1:0] b_value;
  } req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] result;
    logic [WORD_BITS-1:0] remainder;
  } rsp_t;

  // Working word handed from cell to cell. For a multiply, lo is the running
  // sum, a the shifted multiplicand and b the shifted multiplier. For a
  // divide, hi is the partial remainder, lo the dividend/quotient shift
  // register and b the divisor. Add and subtract results ride in lo.
  typedef struct packed {
    op_t                  op;
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] hi;
    logic [WORD_BITS-1:0] lo;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/bau_cell.sv @@
// One step cell of the arithmetic chain: a shift-add step or a restoring
// division step, with its own valid/ready register. Depends on bau_pkg.
`default_nettype none

module bau_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bau_pkg::stage_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bau_pkg::stage_t      out_data
);
  import bau_pkg::*;

  logic                 valid;
  stage_t               data;
  stage_t               step;
  logic [WORD_BITS-1:0] shifted;
  logic [WORD_BITS-1:0] trial;

  always_comb begin
    shifted = {in_data.hi[WORD_BITS-2:0], in_data.lo[WORD_BITS-1]};
    trial   = shifted - in_data.b;
    step    = in_data;
    unique case (in_data.op)
      OP_MUL: begin
        step.lo = in_data.lo + (in_data.b[0] ? in_data.a : '0);
        step.a  = {in_data.a[WORD_BITS-2:0], 1'b0};
        step.b  = {1'b0, in_data.b[WORD_BITS-1:1]};
      end
      OP_DIV: begin
        // A negative trial remainder is restored, which leaves the shifted value.
        if (trial[WORD_BITS-1]) begin
          step.hi = shifted;
          step.lo = {in_data.lo[WORD_BITS-2:0], 1'b0};
        end else begin
          step.hi = trial;
          step.lo = {in_data.lo[WORD_BITS-2:0], 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= step;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |=> valid && $stable(data))
    else $error("cell lost or changed a stalled request");

  a_take_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid)
    else $error("cell accepted a request but holds nothing");

  a_hi_clear_unless_div: assert property (@(posedge clk) disable iff (rst)
    valid && data.op != OP_DIV |-> data.hi == '0)
    else $error("high word set for an operation other than divide");

endmodule

`default_nettype wire

@@ rtl/byte_alu_add_sub_mul_div_core.sv @@
// Byte arithmetic unit: add, subtract, shift-add multiply and restoring divide.
// Top level; depends on bau_pkg and bau_cell.
//
// Usage:
//   The request channel (req_valid, req_ready, req) carries an operation code
//   and two operand bytes. The response channel (rsp_valid, rsp_ready, rsp)
//   returns the low byte of the sum, difference, product or quotient, and the
//   division remainder (zero for the other operations).
//   Every request passes through a chain of WORD_BITS identical cells, one
//   multiply or division step per cell; add and subtract are formed on entry
//   and simply ride the chain. The request is registered in each cell in turn,
//   and rsp_valid is the valid register of the last cell. One request is
//   accepted every cycle as long as the receiver does not stall.
//   Each cell has its own valid/ready register, so when the receiver stalls
//   the chain fills up behind the waiting response and req_ready falls only
//   once every cell is occupied; bubbles are squeezed out.
//   Reset (rst, synchronous) empties the chain; no request is in flight
//   afterwards and req_ready is high in the next cycle.
`default_nettype none

module byte_alu_add_sub_mul_div_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bau_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output bau_pkg::rsp_t      rsp
);
  import bau_pkg::*;

  stage_t                 link_data [WORD_BITS+1];
  logic [WORD_BITS:0]     link_valid;
  logic [WORD_BITS:0]     link_ready;
  stage_t                 entry;

  always_comb begin
    entry.op = req.op;
    entry.a  = req.a_value;
    entry.b  = req.b_value;
    entry.hi = '0;
    entry.lo = '0;
    unique case (req.op)
      OP_ADD: entry.lo = req.a_value + req.b_value;
      OP_SUB: entry.lo = req.a_value - req.b_value;
      OP_MUL: entry.lo = '0;
      OP_DIV: begin
        // The partial remainder starts as the sign extension of the dividend.
        entry.hi = {WORD_BITS{req.a_value[WORD_BITS-1]}};
        entry.lo = req.a_value;
      end
      default: entry.lo = '0;
    endcase
  end

  assign link_data[0]  = entry;
  assign link_valid[0] = req_valid;
  assign req_ready     = link_ready[0];

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    bau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  assign link_ready[WORD_BITS] = rsp_ready;
  assign rsp_valid     = link_valid[WORD_BITS];
  assign rsp.result    = link_data[WORD_BITS].lo;
  assign rsp.remainder = link_data[WORD_BITS].hi;

endmodule

`default_nettype wire

@@ tb/sv/byte_alu_add_sub_mul_div_checker.sv @@
// Response checker for the byte arithmetic unit: it watches both channels, works out the
// expected answer for every request taken and compares it with each response returned.
// Depends on bau_pkg for the request, response and operation types.
module byte_alu_add_sub_mul_div_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  bau_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  bau_pkg::rsp_t rsp,
  output int            errors,
  output int            in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import bau_pkg::*;

  typedef struct {
    req_t asked;
    rsp_t answer;
  } pending_t;

  pending_t pending_q[$];
  int       error_total = 0;

  function automatic rsp_t alu_outcome(input req_t r);
    logic [WORD_BITS-1:0] acc;
    logic [WORD_BITS-1:0] part_rem;
    logic [WORD_BITS-1:0] quo;
    logic                 in_bit;
    rsp_t                 o;
    o = '0;
    case (r.op)
      OP_ADD: begin
        o.result = r.a_value + r.b_value;
      end
      OP_SUB: begin
        o.result = r.a_value - r.b_value;
      end
      OP_MUL: begin
        acc = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
          if (r.b_value[k]) begin
            acc = acc + (r.a_value << k);
          end
        end
        o.result = acc;
      end
      default: begin
        // Restoring division with no sign correction; the partial remainder
        // starts as the sign extension of the dividend.
        part_rem = {WORD_BITS{r.a_value[WORD_BITS-1]}};
        quo      = r.a_value;
        for (int k = 0; k < WORD_BITS; k++) begin
          in_bit   = quo[WORD_BITS-1];
          part_rem = {part_rem[WORD_BITS-2:0], in_bit};
          quo      = {quo[WORD_BITS-2:0], 1'b0};
          part_rem = part_rem - r.b_value;
          if (part_rem[WORD_BITS-1]) begin
            part_rem = part_rem + r.b_value;
          end else begin
            quo[0] = 1'b1;
          end
        end
        o.result    = quo;
        o.remainder = part_rem;
      end
    endcase
    return o;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_total++;
  endtask

  always @(posedge clk) begin : watch_edge
    pending_t oldest;
    pending_t fresh;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_q.size() == 0) begin
          report_error($sformatf("response result=%h remainder=%h with no request open",
                                 rsp.result, rsp.remainder));
        end else begin
          oldest = pending_q.pop_front();
          if (rsp.result !== oldest.answer.result) begin
            report_error($sformatf("%s a=%h b=%h: result %h, expected %h",
                                   oldest.asked.op.name(), oldest.asked.a_value,
                                   oldest.asked.b_value, rsp.result, oldest.answer.result));
          end
          if (rsp.remainder !== oldest.answer.remainder) begin
            report_error($sformatf("%s a=%h b=%h: remainder %h, expected %h",
                                   oldest.asked.op.name(), oldest.asked.a_value,
                                   oldest.asked.b_value, rsp.remainder,
                                   oldest.answer.remainder));
          end
        end
      end
      if (req_valid && req_ready) begin
        fresh.asked  = req;
        fresh.answer = alu_outcome(req);
        pending_q.push_back(fresh);
      end
    end
    errors    <= error_total;
    in_flight <= pending_q.size();
  end

endmodule

@@ tb/sv/byte_alu_add_sub_mul_div_core_tb.sv @@
// Testbench top for the byte arithmetic unit: drives directed and random requests with
// random gaps and response stalls, and gives the verdict.
// Depends on bau_pkg, byte_alu_add_sub_mul_div_core and byte_alu_add_sub_mul_div_checker.
module byte_alu_add_sub_mul_div_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bau_pkg::*;

  localparam int RANDOM_REQUESTS = 950;
  localparam int LONG_HOLD       = 60;
  localparam int DRAIN_CYCLES    = 24;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;
  int   errors;
  int   in_flight;
  int   responses_taken = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_alu_add_sub_mul_div_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  byte_alu_add_sub_mul_div_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .in_flight (in_flight)
  );

  function automatic req_t mk(input op_t o, input logic [WORD_BITS-1:0] a,
                              input logic [WORD_BITS-1:0] b);
    req_t r;
    r.op      = o;
    r.a_value = a;
    r.b_value = b;
    return r;
  endfunction

  // Operands lean towards the corner values so that they turn up often.
  function automatic logic [WORD_BITS-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'h01;
      default: return WORD_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // A gap of zero keeps valid high, so the next request follows back to back.
  task automatic offer(input req_t r, input int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  initial begin : stimulus
    req_t directed[$];
    int   gap;
    directed = '{
      mk(OP_ADD, 8'h00, 8'h00), mk(OP_ADD, 8'hFF, 8'h01), mk(OP_ADD, 8'h7F, 8'h01),
      mk(OP_ADD, 8'h80, 8'h80), mk(OP_SUB, 8'h5A, 8'h00), mk(OP_SUB, 8'h00, 8'h01),
      mk(OP_SUB, 8'h80, 8'h7F), mk(OP_SUB, 8'hFF, 8'hFF), mk(OP_MUL, 8'hA5, 8'h00),
      mk(OP_MUL, 8'hFF, 8'hFF), mk(OP_MUL, 8'h80, 8'h02), mk(OP_MUL, 8'h0F, 8'h11),
      mk(OP_DIV, 8'h64, 8'h00), mk(OP_DIV, 8'h80, 8'h00), mk(OP_DIV, 8'h64, 8'h07),
      mk(OP_DIV, 8'hF6, 8'h03), mk(OP_DIV, 8'h64, 8'hFD), mk(OP_DIV, 8'hFF, 8'hFF),
      mk(OP_DIV, 8'h7F, 8'h01), mk(OP_DIV, 8'h80, 8'h80), mk(OP_DIV, 8'h00, 8'h05)
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      offer(directed[i], $urandom_range(0, 5));
    end
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // A stretch of back-to-back requests in the middle of the run.
      gap = (n >= 300 && n < 450) ? 0 : $urandom_range(0, 5);
      offer(mk(op_t'($urandom_range(0, 3)), pick_byte(), pick_byte()), gap);
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("byte_alu_add_sub_mul_div_core_tb: done, clean");
    end else begin
      $display("byte_alu_add_sub_mul_div_core_tb: done, errors");
    end
    $finish;
  end

  // The long holds let the chain fill up so that req_ready has to fall.
  initial begin : receiver
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      if (responses_taken == 250 || responses_taken == 700) begin
        hold = LONG_HOLD;
      end else if (responses_taken >= 500 && responses_taken < 620) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 5);
      end
      if (hold > 0) begin
        rsp_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      responses_taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("byte_alu_add_sub_mul_div_core_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bau_pkg.sv
rtl/bau_cell.sv
rtl/byte_alu_add_sub_mul_div_core.sv
tb/sv/byte_alu_add_sub_mul_div_checker.sv
tb/sv/byte_alu_add_sub_mul_div_core_tb.sv
